### rtl/core/bkps_pkg.sv
// Shared types and constants of the bitonic key/payload sorter.
// No dependencies; every other file of the sorter but bkps_fifo refers to this package.
package bkps_pkg;

    localparam int ELEMENT_COUNT_DEF = 16;  // run length, a power of two
    localparam int QUEUE_DEPTH       = 2;   // entries between front and back
    localparam int WORD_W            = 32;  // key and payload width

    // back-end sequencer: gather a run, run the network, drain the run
    typedef enum logic [1:0] {
        BK_LOAD,
        BK_SORT,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] key;
        logic signed [WORD_W-1:0] payload;
    } pair_t;

endpackage

### rtl/core/bkps_front.sv
// Front end of the sorter: accepts key/payload transactions and tags each
// with its position in the run and an end-of-run flag. Uses bkps_pkg.
module bkps_front #(
    parameter int ELEMENT_COUNT = bkps_pkg::ELEMENT_COUNT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [bkps_pkg::WORD_W-1:0]  s_sort_key,
    input  logic signed [bkps_pkg::WORD_W-1:0]  s_payload,
    output logic                                q_valid,
    input  logic                                q_ready,
    output bkps_pkg::pair_t                     q_pair,
    output logic [$clog2(ELEMENT_COUNT)-1:0]    q_idx,
    output logic                                q_last
);

    localparam int IDX_W = $clog2(ELEMENT_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ELEMENT_COUNT - 1);

    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;

    assign s_ready        = q_ready;
    assign q_valid        = s_valid;
    assign q_pair.key     = s_sort_key;
    assign q_pair.payload = s_payload;
    assign q_idx          = cnt_reg;
    assign q_last         = (cnt_reg == LAST_IDX);

    // advance the run position on every accepted transaction, wrap at run end
    always_comb begin
        cnt_next = cnt_reg;
        if (s_valid && q_ready) begin
            cnt_next = q_last ? '0 : cnt_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

### rtl/core/bkps_fifo.sv
// Short transaction queue between the sorter's front and back ends.
// Generic over width and depth; no package dependencies.
module bkps_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push, pop;

    assign in_ready  = (cnt_reg != FULL_CNT);
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

### rtl/core/bkps_back.sv
// Back end of the sorter: register array, one bitonic stage per cycle,
// and the registered result port. Uses bkps_pkg.
module bkps_back #(
    parameter int ELEMENT_COUNT = bkps_pkg::ELEMENT_COUNT_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    output logic                                q_ready,
    input  bkps_pkg::pair_t                     q_pair,
    input  logic [$clog2(ELEMENT_COUNT)-1:0]    q_idx,
    input  logic                                q_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [bkps_pkg::WORD_W-1:0]  m_sorted_key,
    output logic signed [bkps_pkg::WORD_W-1:0]  m_sorted_payload,
    output logic                                m_last_out
);

    localparam int LOG_N = $clog2(ELEMENT_COUNT);
    localparam int IDX_W = LOG_N;
    localparam int EXP_W = $clog2(LOG_N + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ELEMENT_COUNT - 1);
    localparam logic [EXP_W-1:0] TOP_LVL  = EXP_W'(LOG_N);

    typedef struct packed {
        logic pop;
        logic wr_en;
        logic sort_en;
        logic out_load;
    } bk_ctl_t;

    bkps_pkg::back_state_t state_reg, state_next;
    bk_ctl_t               ctl;

    logic signed [bkps_pkg::WORD_W-1:0] key_reg [ELEMENT_COUNT];
    logic signed [bkps_pkg::WORD_W-1:0] pay_reg [ELEMENT_COUNT];
    logic signed [bkps_pkg::WORD_W-1:0] stage_key [ELEMENT_COUNT];
    logic signed [bkps_pkg::WORD_W-1:0] stage_pay [ELEMENT_COUNT];

    logic [EXP_W-1:0] lvl_reg, lvl_next;     // log2 of the current block size
    logic [EXP_W-1:0] dexp_reg, dexp_next;   // log2 of the compare distance
    logic             flip_reg, flip_next;   // flip stage versus half-cleaner
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             last_stage;
    logic             out_free;

    logic                               m_valid_reg, m_valid_next;
    logic signed [bkps_pkg::WORD_W-1:0] out_key_reg;
    logic signed [bkps_pkg::WORD_W-1:0] out_pay_reg;
    logic                               out_last_reg;

    logic [IDX_W-1:0] d_vec, d_dbl, mask;

    assign out_free   = !m_valid_reg || m_ready;
    assign last_stage = (dexp_reg == '0) && (lvl_reg == TOP_LVL);
    assign q_ready    = ctl.pop;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bkps_pkg::BK_LOAD: begin
                if (q_valid && q_last) state_next = bkps_pkg::BK_SORT;
            end
            bkps_pkg::BK_SORT: begin
                if (last_stage) state_next = bkps_pkg::BK_EMIT;
            end
            bkps_pkg::BK_EMIT: begin
                if (out_free && rd_idx_reg == LAST_IDX) state_next = bkps_pkg::BK_LOAD;
            end
            default: state_next = bkps_pkg::BK_LOAD;
        endcase
    end

    // state outputs; while draining, refill only entries already sent
    always_comb begin
        ctl = '0;
        unique case (state_reg)
            bkps_pkg::BK_LOAD: begin
                ctl.pop   = 1'b1;
                ctl.wr_en = q_valid;
            end
            bkps_pkg::BK_SORT: begin
                ctl.sort_en = 1'b1;
            end
            bkps_pkg::BK_EMIT: begin
                ctl.out_load = out_free;
                ctl.pop      = (q_idx < rd_idx_reg);
                ctl.wr_en    = q_valid && (q_idx < rd_idx_reg);
            end
            default: ctl = '0;
        endcase
    end

    // stage selection: partner is i ^ mask, lower side has the distance bit clear
    always_comb begin
        d_vec = IDX_W'(1) << dexp_reg;
        d_dbl = d_vec << 1;
        mask  = flip_reg ? (d_dbl - IDX_W'(1)) : d_vec;
    end

    for (genvar i = 0; i < ELEMENT_COUNT; i++) begin : g_cx
        logic [IDX_W-1:0]                   pos;
        logic [IDX_W-1:0]                   mate;
        logic                               is_lo;
        logic signed [bkps_pkg::WORD_W-1:0] lo_key;
        logic signed [bkps_pkg::WORD_W-1:0] hi_key;
        logic                               do_swap;

        assign pos     = IDX_W'(i);
        assign mate    = pos ^ mask;
        assign is_lo   = ((pos & d_vec) == '0);
        assign lo_key  = is_lo ? key_reg[i] : key_reg[mate];
        assign hi_key  = is_lo ? key_reg[mate] : key_reg[i];
        // equal keys swap as well
        assign do_swap = (lo_key >= hi_key);
        assign stage_key[i] = do_swap ? key_reg[mate] : key_reg[i];
        assign stage_pay[i] = do_swap ? pay_reg[mate] : pay_reg[i];
    end

    // stage sequencer and drain pointer
    always_comb begin
        lvl_next    = lvl_reg;
        dexp_next   = dexp_reg;
        flip_next   = flip_reg;
        rd_idx_next = rd_idx_reg;
        if (state_reg == bkps_pkg::BK_LOAD) begin
            lvl_next  = EXP_W'(1);
            dexp_next = '0;
            flip_next = 1'b1;
        end else if (ctl.sort_en) begin
            if (dexp_reg == '0) begin
                lvl_next  = lvl_reg + EXP_W'(1);
                dexp_next = lvl_reg;
                flip_next = 1'b1;
            end else begin
                dexp_next = dexp_reg - EXP_W'(1);
                flip_next = 1'b0;
            end
        end
        if (ctl.out_load) begin
            rd_idx_next = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + IDX_W'(1);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctl.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bkps_pkg::BK_LOAD;
            lvl_reg     <= '0;
            dexp_reg    <= '0;
            flip_reg    <= 1'b0;
            rd_idx_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            lvl_reg     <= lvl_next;
            dexp_reg    <= dexp_next;
            flip_reg    <= flip_next;
            rd_idx_reg  <= rd_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.sort_en) begin
            for (int k = 0; k < ELEMENT_COUNT; k++) begin
                key_reg[k] <= stage_key[k];
                pay_reg[k] <= stage_pay[k];
            end
        end else if (ctl.wr_en) begin
            key_reg[q_idx] <= q_pair.key;
            pay_reg[q_idx] <= q_pair.payload;
        end
        if (ctl.out_load) begin
            out_key_reg  <= key_reg[rd_idx_reg];
            out_pay_reg  <= pay_reg[rd_idx_reg];
            out_last_reg <= (rd_idx_reg == LAST_IDX);
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_sorted_key     = out_key_reg;
    assign m_sorted_payload = out_pay_reg;
    assign m_last_out       = out_last_reg;

endmodule

### rtl/core/bitonic_key_payload_sorter.sv
// Top level of the bitonic key/payload sorter: front end, queue, back end.
// Depends on bkps_pkg, bkps_front, bkps_fifo and bkps_back.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  input    | s_valid / s_ready  | s_sort_key, s_payload (signed 32 bit)
//  result   | m_valid / m_ready  | m_sorted_key, m_sorted_payload, m_last_out
//
// Timing: a run of ELEMENT_COUNT = N transactions loads at one per cycle, then
// the network applies one bitonic stage of N/2 compare-swaps per cycle over
// the register array, then N results leave at one per cycle while m_ready is
// high. Loading of the next run overlaps the drain of the previous one.
// Reset (aresetn low, synchronous) empties the queue, restarts the run count
// and drops any pending result; the arrays need no clearing.
// Stalls: the two-entry queue absorbs two transactions while the back end
// sorts or a result waits on m_ready, then s_ready drops until the back end
// pops again; the result register holds until taken.
module bitonic_key_payload_sorter #(
    parameter int ELEMENT_COUNT = bkps_pkg::ELEMENT_COUNT_DEF  // power of two, 2..64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [bkps_pkg::WORD_W-1:0]  s_sort_key,
    input  logic signed [bkps_pkg::WORD_W-1:0]  s_payload,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [bkps_pkg::WORD_W-1:0]  m_sorted_key,
    output logic signed [bkps_pkg::WORD_W-1:0]  m_sorted_payload,
    output logic                                m_last_out
);

    localparam int IDX_W = $clog2(ELEMENT_COUNT);
    localparam int Q_W   = IDX_W + 1 + $bits(bkps_pkg::pair_t);

    // front end to queue
    logic             qin_valid, qin_ready;
    bkps_pkg::pair_t  qin_pair;
    logic [IDX_W-1:0] qin_idx;
    logic             qin_last;

    // queue to back end
    logic             qout_valid, qout_ready;
    bkps_pkg::pair_t  qout_pair;
    logic [IDX_W-1:0] qout_idx;
    logic             qout_last;
    logic [Q_W-1:0]   qout_data;

    // tag each transaction with its run position
    bkps_front #(
        .ELEMENT_COUNT(ELEMENT_COUNT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_sort_key (s_sort_key),
        .s_payload  (s_payload),
        .q_valid    (qin_valid),
        .q_ready    (qin_ready),
        .q_pair     (qin_pair),
        .q_idx      (qin_idx),
        .q_last     (qin_last)
    );

    // hold tagged transactions while the back end is busy
    bkps_fifo #(
        .WIDTH(Q_W),
        .DEPTH(bkps_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (qin_valid),
        .in_ready  (qin_ready),
        .in_data   ({qin_idx, qin_last, qin_pair}),
        .out_valid (qout_valid),
        .out_ready (qout_ready),
        .out_data  (qout_data)
    );

    assign {qout_idx, qout_last, qout_pair} = qout_data;

    // store, sort and drain the run
    bkps_back #(
        .ELEMENT_COUNT(ELEMENT_COUNT)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (qout_valid),
        .q_ready          (qout_ready),
        .q_pair           (qout_pair),
        .q_idx            (qout_idx),
        .q_last           (qout_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sorted_key     (m_sorted_key),
        .m_sorted_payload (m_sorted_payload),
        .m_last_out       (m_last_out)
    );

    // the run counter restarts after an end-of-run transaction
    a_run_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (qin_valid && qin_ready && qin_last) |=> (qin_idx == '0))
        else $error("run position did not restart after end of run");

    // taking the last transaction of a run starts sorting, so no pop follows
    a_sort_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (qout_valid && qout_ready && qout_last) |=> !qout_ready)
        else $error("queue popped while the network is sorting");

    // consecutive pops never carry the same run position
    a_pop_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        (qout_valid && qout_ready && !qout_last) |=> !(qout_valid && qout_ready
            && (qout_idx == $past(qout_idx))))
        else $error("same run position popped twice in a row");

endmodule

### bench/bitonic_key_payload_sorter_tb.sv
// Self-checking bench for the bitonic key/payload sorter: drives runs of
// key/payload transactions and checks each sorted run against a local sort.
// Depends on bkps_pkg and bitonic_key_payload_sorter.
module bitonic_key_payload_sorter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_W = bkps_pkg::WORD_W;
    localparam int N      = bkps_pkg::ELEMENT_COUNT_DEF;

    // one sorted word as it should leave the block
    typedef struct {
        logic signed [WORD_W-1:0] key;
        logic signed [WORD_W-1:0] payload;
        logic                     last;
    } sorted_word_t;

    // shapes of key sequence used to fill a run
    typedef enum {
        PAT_RANDOM,
        PAT_NARROW,
        PAT_ASCEND,
        PAT_DESCEND,
        PAT_FLAT
    } run_pattern_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [WORD_W-1:0] s_sort_key;
    logic signed [WORD_W-1:0] s_payload;
    logic                     m_valid;
    logic                     m_ready;
    logic signed [WORD_W-1:0] m_sorted_key;
    logic signed [WORD_W-1:0] m_sorted_payload;
    logic                     m_last_out;

    // local copy of the run being gathered, and the words it must produce
    bkps_pkg::pair_t run_pairs [N];
    int              run_fill = 0;
    sorted_word_t    pending_sorted_q [$];

    int mismatch_count  = 0;
    bit idle_on         = 1'b1;  // both sides insert random gaps when set
    int rx_stall_cycles = 0;     // per-result receiver stall, redrawn on each result
    int rx_hold_cycles  = 0;     // long receiver hold-off requested by a test

    bitonic_key_payload_sorter #(
        .ELEMENT_COUNT(N)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sort_key      (s_sort_key),
        .s_payload       (s_payload),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_sorted_key    (m_sorted_key),
        .m_sorted_payload(m_sorted_payload),
        .m_last_out      (m_last_out)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Compare-swap on the local run: exchange when the lower key is greater
    // than or equal to the upper one, so equal keys trade places too.
    function automatic void compare_swap(int lo, int hi);
        bkps_pkg::pair_t tmp;
        if ($signed(run_pairs[lo].key) >= $signed(run_pairs[hi].key)) begin
            tmp           = run_pairs[lo];
            run_pairs[lo] = run_pairs[hi];
            run_pairs[hi] = tmp;
        end
    endfunction

    // Store one accepted transaction; on the last one of a run, sort the run
    // through the same bitonic network and queue the N words it yields.
    function automatic void gather_and_sort(logic signed [WORD_W-1:0] key,
                                            logic signed [WORD_W-1:0] payload);
        sorted_word_t word;
        run_pairs[run_fill].key     = key;
        run_pairs[run_fill].payload = payload;
        run_fill++;
        if (run_fill < N)
            return;
        for (int s = 2; s <= N; s *= 2) begin
            // flip stage: mirror pairs inside each block
            for (int b = 0; b < N; b += s)
                for (int i = 0; i < s / 2; i++)
                    compare_swap(b + i, b + s - 1 - i);
            // half-cleaners: distance s/4 down to 1
            for (int h = s / 4; h >= 1; h /= 2)
                for (int b = 0; b < N; b += 2 * h)
                    for (int i = 0; i < h; i++)
                        compare_swap(b + i, b + i + h);
        end
        for (int i = 0; i < N; i++) begin
            word.key     = run_pairs[i].key;
            word.payload = run_pairs[i].payload;
            word.last    = (i == N - 1);
            pending_sorted_q.push_back(word);
        end
        run_fill = 0;
    endfunction

    // Offer one transaction. Entered and left on a falling edge; valid stays
    // high between back-to-back transactions and drops only for a gap.
    task automatic send_pair(logic signed [WORD_W-1:0] key,
                             logic signed [WORD_W-1:0] payload);
        int gap;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_sort_key <= key;
        s_payload  <= payload;
        // wait for the handshake, sampled at the rising edge
        do
            @(posedge aclk);
        while (!s_ready);
        gather_and_sort(key, payload);
        @(negedge aclk);
    endtask

    // Drop valid after a batch so nothing is offered while a test waits.
    task automatic release_input();
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic signed [WORD_W-1:0] pattern_key(run_pattern_t pat, int idx,
                                                             logic signed [WORD_W-1:0] base);
        case (pat)
            PAT_NARROW:  return $signed($urandom_range(0, 6)) - 3;  // many ties around zero
            PAT_ASCEND:  return base + idx;
            PAT_DESCEND: return base - idx;
            PAT_FLAT:    return base;
            default:     return $urandom;
        endcase
    endfunction

    // One full run with a randomly chosen key shape and random payloads.
    task automatic send_run();
        run_pattern_t             pat;
        logic signed [WORD_W-1:0] base;
        int                       pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1:    pat = PAT_NARROW;
            2:       pat = PAT_ASCEND;
            3:       pat = PAT_DESCEND;
            4:       pat = PAT_FLAT;
            default: pat = PAT_RANDOM;
        endcase
        base = $urandom;
        for (int i = 0; i < N; i++)
            send_pair(pattern_key(pat, i, base), $urandom);
    endtask

    // Extremes of both fields, sign crossings, alternating bit patterns and
    // a triple of equal keys whose payloads show the swap-on-equal order.
    task automatic test_directed_extremes();
        logic signed [WORD_W-1:0] keys [N];
        logic signed [WORD_W-1:0] pays [N];
        keys = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1,
                 32'sd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0,
                 32'sd5, 32'sd5, 32'sd5, 32'sh5555_5555,
                 32'shAAAA_AAAA, -32'sd2, 32'sd2, 32'sh7FFF_FFFE};
        pays = '{32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1, 32'sd0,
                 32'sh5555_5555, 32'shAAAA_AAAA, 32'sd6, 32'sd7,
                 32'sd100, 32'sd101, 32'sd102, 32'sd11,
                 32'sd12, 32'sd13, 32'sd14, 32'sd15};
        for (int i = 0; i < N; i++)
            send_pair(keys[i], pays[i]);
        release_input();
    endtask

    // Random runs with random gaps on both sides.
    task automatic test_random_runs(int runs);
        idle_on = 1'b1;
        for (int r = 0; r < runs; r++)
            send_run();
        release_input();
    endtask

    // Full rate on both sides: no gaps, no stalls.
    task automatic test_back_to_back(int runs);
        idle_on = 1'b0;
        for (int r = 0; r < runs; r++)
            send_run();
        release_input();
        idle_on = 1'b1;
    endtask

    // Hold the receiver off long enough that the block fills and lowers
    // s_ready while the sender keeps offering transactions.
    task automatic test_output_holdoff(int runs);
        rx_hold_cycles = 400;
        for (int r = 0; r < runs; r++)
            send_run();
        release_input();
    endtask

    // Pause the sender after each run until every sorted word has arrived.
    task automatic test_pause_until_drained(int runs);
        for (int r = 0; r < runs; r++) begin
            send_run();
            release_input();
            wait (pending_sorted_q.size() == 0);
            @(negedge aclk);
        end
    endtask

    // Receiver: one decision per falling edge; the long hold-off wins over
    // the per-result stall, otherwise accept.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                m_ready <= 1'b0;
                rx_hold_cycles--;
            end else if (rx_stall_cycles > 0) begin
                m_ready <= 1'b0;
                rx_stall_cycles--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Checker: compare each result transaction with the oldest expected word.
    initial begin
        sorted_word_t want;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                rx_stall_cycles = idle_on ? $urandom_range(0, 14) : 0;
                if (pending_sorted_q.size() == 0) begin
                    $error("unexpected result: key %0d payload %0d last %0b",
                           m_sorted_key, m_sorted_payload, m_last_out);
                    mismatch_count++;
                end else begin
                    want = pending_sorted_q.pop_front();
                    if (m_sorted_key !== want.key) begin
                        $error("sorted_key: expected %0d, got %0d", want.key, m_sorted_key);
                        mismatch_count++;
                    end
                    if (m_sorted_payload !== want.payload) begin
                        $error("sorted_payload: expected %0d, got %0d",
                               want.payload, m_sorted_payload);
                        mismatch_count++;
                    end
                    if (m_last_out !== want.last) begin
                        $error("last_out: expected %0b, got %0b", want.last, m_last_out);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Main sequence: reset once, then the tests in turn, then drain and judge.
    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_sort_key = '0;
        s_payload  = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_extremes();
        test_random_runs(8);
        test_back_to_back(4);
        test_output_holdoff(3);
        test_pause_until_drained(2);
        test_random_runs(4);

        // wait out the last run, then a margin for anything spurious
        wait (pending_sorted_q.size() == 0);
        repeat (60) @(posedge aclk);
        if (mismatch_count == 0 && pending_sorted_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run with every gap and stall maxed.
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
